// ===== hw/rtl/flat_field_pixel_calibration_unit_macros.svh =====
// Assertion macros used by the port-level checker of the calibration unit.
`ifndef FLAT_FIELD_PIXEL_CALIBRATION_UNIT_MACROS_SVH
`define FLAT_FIELD_PIXEL_CALIBRATION_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define FFPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define FFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ffpc_pkg.sv =====
// Shared types, widths and constants of the flat-field pixel calibration unit.
package ffpc_pkg;

    // Field widths.
    localparam int PIX_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int SATL_W     = 20;
    localparam int MINF_W     = 15;
    localparam int CAL_W      = 32;
    localparam int PROD_W     = PIX_W + GAIN_W;
    localparam int BADV_W     = 25;
    localparam int DIV_W      = 15;

    // Divider geometry: quotient width, bits retired per stage, stage count.
    localparam int Q_W        = 39;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = Q_W / DIV_STEP;

    // Two front stages, the divider stages and the output stage.
    localparam int NUM_STAGES = DIV_STAGES + 3;
    localparam int DIV_FIRST  = 2;

    // Register file.
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_SAT_LEVEL = 2'd1;
    localparam logic [1:0] REG_MIN_FLAT  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd4096;
    localparam logic [SATL_W-1:0] SAT_LEVEL_RESET = 20'd60000;
    localparam logic [MINF_W-1:0] MIN_FLAT_RESET = 15'd819;

    // Output limits.
    localparam logic signed [CAL_W-1:0] CAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CAL_W-1:0] CAL_MIN = 32'sh8000_0000;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [SATL_W-1:0] sat_level;
        logic [MINF_W-1:0] min_flat;
    } t_cfg;

    // Per-pixel flags and the bad-pixel value that ride alongside the divider.
    typedef struct packed {
        logic              neg;
        logic              bad;
        logic              zflat;
        logic              mzero;
        logic              sat;
        logic [BADV_W-1:0] bad_val;
    } t_side;

endpackage

// ===== hw/rtl/ffpc_regs.sv =====
// APB register file holding gain, saturation level and minimum flat value.
module ffpc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ffpc_pkg::DATA_W-1:0]  pwdata,
    output logic [ffpc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ffpc_pkg::t_cfg               o_cfg
);

    logic [ffpc_pkg::GAIN_W-1:0] r_gain;
    logic [ffpc_pkg::SATL_W-1:0] r_sat_level;
    logic [ffpc_pkg::MINF_W-1:0] r_min_flat;
    logic                        w_wr;
    logic [1:0]                  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // Register writes in the access phase; unmapped addresses are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= ffpc_pkg::GAIN_RESET;
            r_sat_level <= ffpc_pkg::SAT_LEVEL_RESET;
            r_min_flat  <= ffpc_pkg::MIN_FLAT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                ffpc_pkg::REG_GAIN:      r_gain      <= pwdata[ffpc_pkg::GAIN_W-1:0];
                ffpc_pkg::REG_SAT_LEVEL: r_sat_level <= pwdata[ffpc_pkg::SATL_W-1:0];
                ffpc_pkg::REG_MIN_FLAT:  r_min_flat  <= pwdata[ffpc_pkg::MINF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            ffpc_pkg::REG_GAIN:      prdata = 32'(r_gain);
            ffpc_pkg::REG_SAT_LEVEL: prdata = 32'(r_sat_level);
            ffpc_pkg::REG_MIN_FLAT:  prdata = 32'(r_min_flat);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.gain      = r_gain;
    assign o_cfg.sat_level = r_sat_level;
    assign o_cfg.min_flat  = r_min_flat;

endmodule

// ===== hw/rtl/ffpc_front.sv =====
// Front stages: gain products, bad-pixel test, saturation test and dividend.
module ffpc_front (
    input  logic                              i_clk,
    input  logic                              i_en_a,
    input  logic                              i_en_b,
    input  ffpc_pkg::t_cfg                    i_cfg,
    input  logic [ffpc_pkg::PIX_W-1:0]        i_raw_pixel,
    input  logic [ffpc_pkg::PIX_W-1:0]        i_dark_pixel,
    input  logic signed [ffpc_pkg::PIX_W-1:0] i_flat_pixel,
    input  logic                              i_mask_bad,
    output logic [ffpc_pkg::Q_W-1:0]          o_num,
    output logic [ffpc_pkg::DIV_W-1:0]        o_d,
    output ffpc_pkg::t_side                   o_side
);

    logic                               w_neg;
    logic [ffpc_pkg::PIX_W-1:0]         w_mag;
    logic                               w_bad;
    logic [ffpc_pkg::PROD_W:0]          w_round;

    logic [ffpc_pkg::PROD_W-1:0]        r_prod;
    logic [ffpc_pkg::PROD_W-1:0]        r_mg;
    logic [ffpc_pkg::DIV_W-1:0]         r_d;
    logic                               r_neg;
    logic                               r_bad;
    logic                               r_zflat;
    logic                               r_mzero;

    // Stage A: sign and size of the dark-subtracted count, bad-pixel decision.
    assign w_neg = i_raw_pixel < i_dark_pixel;
    assign w_mag = w_neg ? (i_dark_pixel - i_raw_pixel) : (i_raw_pixel - i_dark_pixel);
    assign w_bad = i_mask_bad || i_flat_pixel[ffpc_pkg::PIX_W-1]
                   || (i_flat_pixel[ffpc_pkg::DIV_W-1:0] < i_cfg.min_flat);

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_prod  <= ffpc_pkg::PROD_W'(i_raw_pixel) * ffpc_pkg::PROD_W'(i_cfg.gain);
            r_mg    <= ffpc_pkg::PROD_W'(w_mag) * ffpc_pkg::PROD_W'(i_cfg.gain);
            r_d     <= i_flat_pixel[ffpc_pkg::DIV_W-1:0];
            r_neg   <= w_neg;
            r_bad   <= w_bad;
            r_zflat <= (i_flat_pixel == '0);
            r_mzero <= (w_mag == '0);
        end
    end

    // Stage B: saturation compare, rounded bad-pixel value, rounded dividend.
    assign w_round = (ffpc_pkg::PROD_W+1)'(r_prod) + (ffpc_pkg::PROD_W+1)'(128);

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            o_side.sat     <= r_prod >= {i_cfg.sat_level, 12'd0};
            o_side.bad_val <= w_round[ffpc_pkg::PROD_W:8];
            o_side.neg     <= r_neg;
            o_side.bad     <= r_bad;
            o_side.zflat   <= r_zflat;
            o_side.mzero   <= r_mzero;
            o_num          <= {1'b0, r_mg, 6'd0} + ffpc_pkg::Q_W'(r_d >> 1);
            o_d            <= r_d;
        end
    end

endmodule

// ===== hw/rtl/ffpc_div_stage.sv =====
// One divider stage: retires three quotient bits by restoring division.
module ffpc_div_stage (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ffpc_pkg::DIV_W-1:0]  i_rem,
    input  logic [ffpc_pkg::Q_W-1:0]    i_num,
    input  logic [ffpc_pkg::DIV_W-1:0]  i_d,
    input  ffpc_pkg::t_side             i_side,
    output logic [ffpc_pkg::DIV_W-1:0]  o_rem,
    output logic [ffpc_pkg::Q_W-1:0]    o_num,
    output logic [ffpc_pkg::DIV_W-1:0]  o_d,
    output ffpc_pkg::t_side             o_side
);

    logic [ffpc_pkg::DIV_W-1:0] n_rem;
    logic [ffpc_pkg::Q_W-1:0]   n_num;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
        logic [ffpc_pkg::DIV_W:0] t;
        n_rem = i_rem;
        n_num = i_num;
        for (int k = 0; k < ffpc_pkg::DIV_STEP; k++) begin
            t     = {n_rem, n_num[ffpc_pkg::Q_W-1]};
            n_num = {n_num[ffpc_pkg::Q_W-2:0], 1'b0};
            if (t >= {1'b0, i_d}) begin
                t        = t - {1'b0, i_d};
                n_num[0] = 1'b1;
            end
            n_rem = t[ffpc_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_num  <= n_num;
            o_d    <= i_d;
            o_side <= i_side;
        end
    end

endmodule

// ===== hw/rtl/ffpc_back.sv =====
// Output stage: sign, clamp and selection between corrected and bad-pixel values.
module ffpc_back (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [ffpc_pkg::Q_W-1:0]           i_q,
    input  ffpc_pkg::t_side                    i_side,
    output logic signed [ffpc_pkg::CAL_W-1:0]  o_calibrated,
    output logic                               o_saturated,
    output logic                               o_bad
);

    logic signed [ffpc_pkg::CAL_W-1:0] n_cal;
    logic                              w_big;

    // Quotients of 2^31 and above are clamped to the output limit for either sign.
    assign w_big = (i_q[ffpc_pkg::Q_W-1:ffpc_pkg::CAL_W-1] != '0);

    always_comb begin
        priority if (i_side.bad) begin
            n_cal = ffpc_pkg::CAL_W'(i_side.bad_val);
        end else if (i_side.zflat) begin
            if (i_side.mzero) begin
                n_cal = '0;
            end else begin
                n_cal = i_side.neg ? ffpc_pkg::CAL_MIN : ffpc_pkg::CAL_MAX;
            end
        end else if (w_big) begin
            n_cal = i_side.neg ? ffpc_pkg::CAL_MIN : ffpc_pkg::CAL_MAX;
        end else if (i_side.neg) begin
            n_cal = -$signed(i_q[ffpc_pkg::CAL_W-1:0]);
        end else begin
            n_cal = $signed(i_q[ffpc_pkg::CAL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_calibrated <= n_cal;
            o_saturated  <= i_side.sat;
            o_bad        <= i_side.bad;
        end
    end

endmodule

// ===== hw/rtl/flat_field_pixel_calibration_unit.sv =====
// Top level of the flat-field pixel calibration unit.
//
// Pixels arrive on the input channel (i_valid / o_stall) as raw count, dark
// count, signed Q1.14 flat value and bad-pixel mask bit. Each pixel yields one
// beat on the output channel (o_valid / i_stall): the calibrated value in
// electrons with 4 fraction bits, a saturation flag and a bad-pixel flag.
// Gain, saturation level and minimum flat value sit in an APB register file
// at byte addresses 0, 4 and 8; write them only while the pipeline is empty.
//
// Throughput is one pixel per cycle unless the pipeline is full while the receiver
// stalls. An accepted input beat passes through two front stages for the gain
// products and tests, 13 divider stages retiring 3 quotient bits each, and the
// output register. Every stage has its own valid bit, so empty stages close up
// while the receiver stalls, and input beats keep entering until the pipeline is
// full; only then is o_stall raised. Reset empties the pipeline and loads the
// register defaults (gain 1.0, saturation level 60000, minimum flat 819).
module flat_field_pixel_calibration_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffpc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ffpc_pkg::DATA_W-1:0]        pwdata,
    output logic [ffpc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [ffpc_pkg::PIX_W-1:0]         i_raw_pixel,
    input  logic [ffpc_pkg::PIX_W-1:0]         i_dark_pixel,
    input  logic signed [ffpc_pkg::PIX_W-1:0]  i_flat_pixel,
    input  logic                               i_mask_bad,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [ffpc_pkg::CAL_W-1:0]  o_calibrated,
    output logic                               o_saturated,
    output logic                               o_bad
);

    localparam int NS = ffpc_pkg::NUM_STAGES;
    localparam int ND = ffpc_pkg::DIV_STAGES;

    ffpc_pkg::t_cfg             w_cfg;
    logic [NS-1:0]              r_v;
    logic [NS-1:0]              w_load;

    logic [ffpc_pkg::DIV_W-1:0] w_rem  [0:ND];
    logic [ffpc_pkg::Q_W-1:0]   w_num  [0:ND];
    logic [ffpc_pkg::DIV_W-1:0] w_d    [0:ND];
    ffpc_pkg::t_side            w_side [0:ND];

    ffpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // A stage may load when it or any later stage is empty, or the output drains.
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            w_load[s] = !i_stall || ((~r_v >> s) != '0);
        end
    end

    assign o_stall = !w_load[0];
    assign o_valid = r_v[NS-1];

    // Valid bits move with their data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_load[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    ffpc_front u_front (
        .i_clk        (i_clk),
        .i_en_a       (w_load[0]),
        .i_en_b       (w_load[1]),
        .i_cfg        (w_cfg),
        .i_raw_pixel  (i_raw_pixel),
        .i_dark_pixel (i_dark_pixel),
        .i_flat_pixel (i_flat_pixel),
        .i_mask_bad   (i_mask_bad),
        .o_num        (w_num[0]),
        .o_d          (w_d[0]),
        .o_side       (w_side[0])
    );

    assign w_rem[0] = '0;

    // Divider chain.
    for (genvar g = 0; g < ND; g++) begin : g_div
        ffpc_div_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (w_load[ffpc_pkg::DIV_FIRST + g]),
            .i_rem  (w_rem[g]),
            .i_num  (w_num[g]),
            .i_d    (w_d[g]),
            .i_side (w_side[g]),
            .o_rem  (w_rem[g+1]),
            .o_num  (w_num[g+1]),
            .o_d    (w_d[g+1]),
            .o_side (w_side[g+1])
        );
    end

    ffpc_back u_back (
        .i_clk        (i_clk),
        .i_en         (w_load[NS-1]),
        .i_q          (w_num[ND]),
        .i_side       (w_side[ND]),
        .o_calibrated (o_calibrated),
        .o_saturated  (o_saturated),
        .o_bad        (o_bad)
    );

endmodule

// ===== hw/rtl/ffpc_checker.sv =====
// Port-level checks of the calibration unit and their binding to the top level.
`include "flat_field_pixel_calibration_unit_macros.svh"

module ffpc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [ffpc_pkg::CAL_W-1:0]  o_calibrated,
    input logic                               o_saturated,
    input logic                               o_bad
);

    // A waiting output beat holds until it is taken.
    `FFPC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_calibrated) && $stable(o_saturated) && $stable(o_bad), "output beat changed while stalled")

    // With the output register empty the pipeline always has room.
    `FFPC_ASSERT_SAME(a_no_stall_empty, !o_valid, !o_stall, "input stalled with empty output stage")

    // A bad-pixel value is the rounded raw product, never negative and always below 2^25.
    `FFPC_ASSERT_SAME(a_bad_range, o_valid && o_bad, o_calibrated[31:25] == 7'd0, "bad-pixel value out of range")

    // The input is stalled only while an output beat waits under a receiver stall.
    `FFPC_ASSERT_NEXT(a_stall_needs_out, o_stall, $past(o_valid) && $past(i_stall), "input stalled without a waiting output beat")

endmodule

bind flat_field_pixel_calibration_unit ffpc_checker u_checker (.*);

// ===== sim/ffpc_pixel_checker.sv =====
// Checker for the flat-field pixel calibration unit: predicts each pixel result and compares.
`timescale 1ns / 100ps

module ffpc_pixel_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffpc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ffpc_pkg::DATA_W-1:0]        pwdata,
    input  logic                               pready,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic [ffpc_pkg::PIX_W-1:0]         i_raw_pixel,
    input  logic [ffpc_pkg::PIX_W-1:0]         i_dark_pixel,
    input  logic signed [ffpc_pkg::PIX_W-1:0]  i_flat_pixel,
    input  logic                               i_mask_bad,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic signed [ffpc_pkg::CAL_W-1:0]  o_calibrated,
    input  logic                               o_saturated,
    input  logic                               o_bad,
    output int                                 fail_count,
    output int                                 pending_pixels,
    output int                                 checked_pixels,
    output int                                 bad_pixels,
    output int                                 sat_pixels,
    output int                                 clamped_pixels
);
    import ffpc_pkg::*;

    typedef struct packed {
        logic signed [CAL_W-1:0] calibrated;
        logic                    saturated;
        logic                    bad;
    } pixel_result_t;

    // Shadow copy of the register file, tracked from the APB writes.
    logic [GAIN_W-1:0] gain_q;
    logic [SATL_W-1:0] sat_level_q;
    logic [MINF_W-1:0] min_flat_q;

    pixel_result_t expected_pixels[$];

    initial begin
        fail_count     = 0;
        pending_pixels = 0;
        checked_pixels = 0;
        bad_pixels     = 0;
        sat_pixels     = 0;
        clamped_pixels = 0;
    end

    // Dark subtraction, flat division and gain, computed at full precision.
    function automatic pixel_result_t calibrate_pixel(
        input logic [PIX_W-1:0]        raw,
        input logic [PIX_W-1:0]        dark,
        input logic signed [PIX_W-1:0] flat
    ,   input logic                    mask
    );
        pixel_result_t res;
        logic [63:0]   prod;
        logic [63:0]   mag;
        logic [63:0]   num;
        logic [63:0]   quo;
        longint        sval;
        int            flat_i;
        int            minf_i;
        logic          neg;
        flat_i = flat;
        minf_i = int'(min_flat_q);
        prod = 64'(raw) * 64'(gain_q);
        res.saturated = (prod >= (64'(sat_level_q) << 12));
        res.bad = mask || (flat_i < minf_i);
        if (res.bad) begin
            // Bad pixels pass raw times gain, rounded from Q.12 to Q.4.
            res.calibrated = CAL_W'((prod + 64'd128) >> 8);
        end else begin
            neg = (raw < dark);
            mag = neg ? 64'(dark - raw) : 64'(raw - dark);
            if (flat_i == 0) begin
                // A zero flat only gets here with a zero minimum: zero for a zero count, else saturate by sign.
                if (mag == 64'd0) res.calibrated = '0;
                else res.calibrated = neg ? CAL_MIN : CAL_MAX;
            end else begin
                num = mag * 64'(gain_q) * 64'd64;
                quo = (num + 64'(flat_i / 2)) / 64'(flat_i);
                sval = neg ? -longint'(quo) : longint'(quo);
                if (sval > longint'(CAL_MAX)) sval = longint'(CAL_MAX);
                if (sval < longint'(CAL_MIN)) sval = longint'(CAL_MIN);
                res.calibrated = CAL_W'(sval);
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Register tracking, expectation store and result comparison.
    always @(posedge i_clk) begin : scoreboard
        pixel_result_t want;
        pixel_result_t got;
        if (!i_rst_n) begin
            expected_pixels.delete();
            gain_q      <= GAIN_RESET;
            sat_level_q <= SAT_LEVEL_RESET;
            min_flat_q  <= MIN_FLAT_RESET;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_GAIN:      gain_q      <= pwdata[GAIN_W-1:0];
                    REG_SAT_LEVEL: sat_level_q <= pwdata[SATL_W-1:0];
                    REG_MIN_FLAT:  min_flat_q  <= pwdata[MINF_W-1:0];
                    default: ;
                endcase
            end

            if (i_valid && !o_stall) begin
                expected_pixels.push_back(calibrate_pixel(i_raw_pixel, i_dark_pixel,
                                                          i_flat_pixel, i_mask_bad));
            end

            if (o_valid && !i_stall) begin
                got.calibrated = o_calibrated;
                got.saturated  = o_saturated;
                got.bad        = o_bad;
                if (expected_pixels.size() == 0) begin
                    note_failure($sformatf("result beat with nothing expected: cal=%0d sat=%b bad=%b",
                                           got.calibrated, got.saturated, got.bad));
                end else begin
                    want = expected_pixels.pop_front();
                    checked_pixels++;
                    if (want.bad) bad_pixels++;
                    if (want.saturated) sat_pixels++;
                    if (!want.bad && (want.calibrated == CAL_MAX || want.calibrated == CAL_MIN))
                        clamped_pixels++;
                    if (got.calibrated !== want.calibrated || got.saturated !== want.saturated ||
                        got.bad !== want.bad) begin
                        note_failure($sformatf(
                            "pixel %0d: cal exp %0d act %0d, sat exp %b act %b, bad exp %b act %b",
                            checked_pixels, want.calibrated, got.calibrated,
                            want.saturated, got.saturated, want.bad, got.bad));
                    end
                end
            end
        end
        pending_pixels <= expected_pixels.size();
    end

endmodule

// ===== sim/flat_field_pixel_calibration_unit_tb.sv =====
// Testbench top for the flat-field pixel calibration unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module flat_field_pixel_calibration_unit_tb;
    import ffpc_pkg::*;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_W-1:0]           paddr = '0;
    logic [DATA_W-1:0]           pwdata = '0;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [PIX_W-1:0]            i_raw_pixel = '0;
    logic [PIX_W-1:0]            i_dark_pixel = '0;
    logic signed [PIX_W-1:0]     i_flat_pixel = '0;
    logic                        i_mask_bad = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [CAL_W-1:0]     o_calibrated;
    logic                        o_saturated;
    logic                        o_bad;

    int fail_count;
    int pending_pixels;
    int checked_pixels;
    int bad_pixels;
    int sat_pixels;
    int clamped_pixels;

    // Set near the end of the run: both sides stop idling.
    bit quiet = 1'b0;

    // Register values currently programmed, used to aim the random pixels.
    logic [GAIN_W-1:0] cur_gain = GAIN_RESET;
    logic [SATL_W-1:0] cur_sat = SAT_LEVEL_RESET;
    logic [MINF_W-1:0] cur_min_flat = MIN_FLAT_RESET;
    int                settings_used = 1;

    localparam int PHASES = 8;
    localparam int PIXELS_PER_PHASE = 138;
    localparam int QUIET_AFTER = 950;
    localparam int DRAIN_CYCLES = 24;

    flat_field_pixel_calibration_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_raw_pixel  (i_raw_pixel),
        .i_dark_pixel (i_dark_pixel),
        .i_flat_pixel (i_flat_pixel),
        .i_mask_bad   (i_mask_bad),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_calibrated (o_calibrated),
        .o_saturated  (o_saturated),
        .o_bad        (o_bad)
    );

    ffpc_pixel_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_raw_pixel    (i_raw_pixel),
        .i_dark_pixel   (i_dark_pixel),
        .i_flat_pixel   (i_flat_pixel),
        .i_mask_bad     (i_mask_bad),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_calibrated   (o_calibrated),
        .o_saturated    (o_saturated),
        .o_bad          (o_bad),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels),
        .checked_pixels (checked_pixels),
        .bad_pixels     (bad_pixels),
        .sat_pixels     (sat_pixels),
        .clamped_pixels (clamped_pixels)
    );

    // 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5ms;
        $display("Timeout with %0d results still expected.", pending_pixels);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side: random stall bursts until the quiet tail of the run.
    initial begin : receiver_idling
        int n;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 17);
                i_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // One pixel beat; returns once the block has taken it.
    task automatic send_pixel(input logic [PIX_W-1:0] raw, input logic [PIX_W-1:0] dark,
                              input logic signed [PIX_W-1:0] flat, input logic mask);
        i_valid      <= 1'b1;
        i_raw_pixel  <= raw;
        i_dark_pixel <= dark;
        i_flat_pixel <= flat;
        i_mask_bad   <= mask;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Sender side: an occasional random gap between beats, until the quiet tail of the run.
    task automatic sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every result is back and the pipeline is empty.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase until pready, then back to idle.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [GAIN_W-1:0] g, input logic [SATL_W-1:0] s,
                              input logic [MINF_W-1:0] m);
        write_reg(REG_GAIN, DATA_W'(g));
        write_reg(REG_SAT_LEVEL, DATA_W'(s));
        write_reg(REG_MIN_FLAT, DATA_W'(m));
        cur_gain     = g;
        cur_sat      = s;
        cur_min_flat = m;
        settings_used++;
    endtask

    // Random pixel, mostly well-formed, with a share aimed at the corners.
    task automatic send_random_pixel();
        logic [PIX_W-1:0]        raw;
        logic [PIX_W-1:0]        dark;
        logic signed [PIX_W-1:0] flat;
        logic                    mask;
        int                      fv;
        longint                  thr;
        raw  = PIX_W'($urandom);
        dark = PIX_W'($urandom_range(0, 4095));
        flat = PIX_W'($urandom_range(8192, 24576));
        mask = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0: begin
                // Flat right around the minimum.
                fv = int'(cur_min_flat) + $urandom_range(0, 4) - 2;
                if (fv > 32767) fv = 32767;
                flat = PIX_W'(fv);
            end
            1: begin
                flat = PIX_W'($urandom);
                dark = PIX_W'($urandom);
            end
            2: flat = PIX_W'($urandom_range(0, 16));
            3: begin
                // Small raw, with dark equal to it or random in the same range.
                raw  = PIX_W'($urandom_range(0, 1000));
                dark = ($urandom_range(0, 2) == 0) ? raw : PIX_W'($urandom_range(0, 1000));
            end
            4: begin
                // Raw next to the saturation threshold.
                if (cur_gain != 0) begin
                    thr = ((longint'(cur_sat) << 12) / longint'(cur_gain)) +
                          $urandom_range(0, 2) - 1;
                    if (thr > 65535) thr = 65535;
                    if (thr < 0) thr = 0;
                    raw = PIX_W'(thr);
                end
            end
            5: flat = -PIX_W'($urandom_range(1, 32768));
            default: ;
        endcase
        send_pixel(raw, dark, flat, mask);
    endtask

    // Main stimulus.
    initial begin : stimulus
        int sent;
        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels with the reset register values.
        send_pixel(16'd0, 16'd0, 16'sd16384, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'sd16384, 1'b0);
        send_pixel(16'd0, 16'hFFFF, 16'sd16384, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'sd819, 1'b0);
        send_pixel(16'd5000, 16'd100, 16'sd818, 1'b0);
        send_pixel(16'd5000, 16'd100, -16'sd1, 1'b0);
        send_pixel(16'd5000, 16'd100, -16'sd32768, 1'b0);
        send_pixel(16'd5000, 16'd100, 16'sd32767, 1'b0);
        send_pixel(16'd5000, 16'd100, 16'sd16384, 1'b1);
        send_pixel(16'd60000, 16'd0, 16'sd16384, 1'b0);
        send_pixel(16'd59999, 16'd0, 16'sd16384, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'sd16384, 1'b0);
        send_pixel(16'd1, 16'd0, 16'sd3, 1'b0);
        drain_pipeline();

        // Directed pixels at the gain extreme with a zero minimum flat.
        set_config(16'hFFFF, 20'hFFFFF, 15'd0);
        send_pixel(16'hFFFF, 16'd0, 16'sd1, 1'b0);
        send_pixel(16'd0, 16'hFFFF, 16'sd1, 1'b0);
        send_pixel(16'd300, 16'd200, 16'sd0, 1'b0);
        send_pixel(16'd200, 16'd300, 16'sd0, 1'b0);
        send_pixel(16'd777, 16'd777, 16'sd0, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'sd16384, 1'b1);
        send_pixel(16'hFFFF, 16'd0, -16'sd32768, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'sd0, 1'b1);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipeline();
            case (ph)
                0: set_config(GAIN_RESET, SAT_LEVEL_RESET, MIN_FLAT_RESET);
                1: set_config(16'hFFFF, 20'hFFFFF, 15'd0);
                2: set_config(16'd0, 20'd0, 15'h7FFF);
                3: set_config(16'd1, 20'd1, 15'd1);
                7: set_config(GAIN_W'($urandom), SATL_W'($urandom), MINF_W'($urandom));
                default: set_config(GAIN_W'($urandom), SATL_W'($urandom),
                                    MINF_W'($urandom_range(0, 2000)));
            endcase
            for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
                if (sent == QUIET_AFTER) quiet <= 1'b1;
                send_random_pixel();
                sent++;
                sender_gap();
            end
        end

        drain_pipeline();
        $display("Checked %0d pixels under %0d register settings.",
                 checked_pixels, settings_used);
        $display("Of these %0d were flagged bad, %0d saturated and %0d clamped to the limits.",
                 bad_pixels, sat_pixels, clamped_pixels);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
